// ===== hw/rtl/point_in_quad_strip_test_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the point-in-quad-strip test core
// Short forms for the same-cycle and next-cycle implications used by the
// checker.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_QUAD_STRIP_TEST_CORE_ASSERT_SVH
`define POINT_IN_QUAD_STRIP_TEST_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PQST_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pqst same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PQST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pqst next-cycle check failed");

`endif

// ===== hw/rtl/pqst_pkg.sv =====
// ----------------------------------------------------------------------------
// pqst_pkg
// Types, widths and codes shared by the point-in-quad-strip test core.
// ----------------------------------------------------------------------------
package pqst_pkg;

    localparam int COORD_W   = 16;
    localparam int IDX_W     = 8;
    localparam int CNT_W     = 9;
    localparam int TOL_W     = 32;
    localparam int CFG_IDX_W = 1;

    // Datapath widths, sized for exact area arithmetic on 16-bit coordinates.
    localparam int DIFF_W  = 17;
    localparam int PROD_W  = 34;
    localparam int CROSS_W = 35;
    localparam int TRI_W   = 37;
    localparam int QUAD_W  = 38;
    localparam int PARTS_W = 37;
    localparam int AREA_W  = 39;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef logic [CFG_IDX_W-1:0] t_cfg_index;
    localparam t_cfg_index REG_SEGMENT_COUNT  = 1'b0;
    localparam t_cfg_index REG_AREA_TOLERANCE = 1'b1;

    localparam logic [CNT_W-1:0] SEG_COUNT_MIN   = 9'd2;
    localparam logic [CNT_W-1:0] SEG_COUNT_RESET = 9'd2;
    localparam logic [TOL_W-1:0] TOL_RESET       = 32'd5243;

    // One table entry; outer_x sits in the low bits.
    typedef struct packed {
        logic signed [COORD_W-1:0] inner_z;
        logic signed [COORD_W-1:0] inner_x;
        logic signed [COORD_W-1:0] outer_z;
        logic signed [COORD_W-1:0] outer_x;
    } t_corner;

    typedef struct packed {
        logic signed [DIFF_W-1:0] x;
        logic signed [DIFF_W-1:0] z;
    } t_rel;

    typedef struct packed {
        logic             valid;
        logic             seg_valid;
        logic             last;
        logic [IDX_W-1:0] idx;
    } t_seg_tag;

    typedef struct packed {
        logic [IDX_W-1:0] addr;
        t_seg_tag         tag;
    } t_rd_req;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_corner          data;
    } t_wr_req;

    typedef struct packed {
        logic             valid;
        logic             last;
        logic             hit;
        logic [IDX_W-1:0] idx;
    } t_seg_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH
    } t_state;

endpackage

// ===== hw/rtl/pqst_if.sv =====
// ----------------------------------------------------------------------------
// pqst interfaces
// Request, response and configuration channels of the strip test core.
// ----------------------------------------------------------------------------
interface pqst_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [7:0]  entry_index;
    logic signed [15:0] outer_x;
    logic signed [15:0] outer_z;
    logic signed [15:0] inner_x;
    logic signed [15:0] inner_z;
    logic signed [15:0] point_x;
    logic signed [15:0] point_z;

    modport source (
        output valid, cmd, entry_index, outer_x, outer_z, inner_x, inner_z,
               point_x, point_z,
        input  ready
    );
    modport sink (
        input  valid, cmd, entry_index, outer_x, outer_z, inner_x, inner_z,
               point_x, point_z,
        output ready
    );
endinterface

interface pqst_rsp_if;
    logic       valid;
    logic       ready;
    logic       on_strip;
    logic [7:0] hit_segment;

    modport source (output valid, on_strip, hit_segment, input ready);
    modport sink (input valid, on_strip, hit_segment, output ready);
endinterface

interface pqst_cfg_if;
    logic                  valid;
    logic                  ready;
    pqst_pkg::t_cfg_index  index;
    logic [31:0]           data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/pqst_table.sv =====
// ----------------------------------------------------------------------------
// pqst_table
// Corner pair memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pqst_table #(
    parameter int DEPTH = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pqst_pkg::t_wr_req  i_wr,
    input  pqst_pkg::t_rd_req  i_rd,
    output pqst_pkg::t_corner  o_rd_data,
    output pqst_pkg::t_seg_tag o_rd_tag
);
    import pqst_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);

    t_corner  r_mem [DEPTH];
    t_corner  r_rd_data;
    t_seg_tag r_rd_tag;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr[ADDR_W-1:0]] <= i_wr.data;
        end
        if (i_rd.tag.valid) begin
            r_rd_data <= r_mem[i_rd.addr[ADDR_W-1:0]];
        end
    end

    // The tag travels with the read so that the datapath knows what it got.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_tag <= '0;
        end else begin
            r_rd_tag <= i_rd.tag;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_rd_tag  = r_rd_tag;

endmodule

// ===== hw/rtl/pqst_area.sv =====
// ----------------------------------------------------------------------------
// pqst_area
// Six-stage area pipeline: one quad segment enters per cycle.
// ----------------------------------------------------------------------------
module pqst_area (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pqst_pkg::t_corner         i_data,
    input  pqst_pkg::t_seg_tag        i_tag,
    input  logic signed [15:0]        i_px,
    input  logic signed [15:0]        i_pz,
    input  logic [31:0]               i_tol,
    output pqst_pkg::t_seg_res        o_res
);
    import pqst_pkg::*;

    function automatic logic [CROSS_W-1:0] abs_cross(input logic signed [CROSS_W-1:0] v);
        return v[CROSS_W-1] ? CROSS_W'(-v) : CROSS_W'(v);
    endfunction

    function automatic logic [TRI_W-1:0] abs_tri(input logic signed [TRI_W-1:0] v);
        return v[TRI_W-1] ? TRI_W'(-v) : TRI_W'(v);
    endfunction

    function automatic t_rel rel_of(input logic signed [COORD_W-1:0] x,
                                    input logic signed [COORD_W-1:0] z,
                                    input logic signed [COORD_W-1:0] px,
                                    input logic signed [COORD_W-1:0] pz);
        t_rel r;
        r.x = DIFF_W'(x) - DIFF_W'(px);
        r.z = DIFF_W'(z) - DIFF_W'(pz);
        return r;
    endfunction

    // Previous entry: corner pair i while entry i+1 is on the read port.
    t_corner r_prev;

    // Stage A: corners relative to the point.
    t_seg_tag r_a_tag;
    t_rel     r_a_1, r_a_2, r_a_3, r_a_4;

    // Stage B: products for the five cross terms.
    t_seg_tag r_b_tag;
    logic signed [PROD_W-1:0] r_b_12a, r_b_12b, r_b_13a, r_b_13b, r_b_34a, r_b_34b;
    logic signed [PROD_W-1:0] r_b_42a, r_b_42b, r_b_23a, r_b_23b;

    // Stage C: cross terms.
    t_seg_tag r_c_tag;
    logic signed [CROSS_W-1:0] r_c_12, r_c_13, r_c_34, r_c_42, r_c_23;

    // Stage D: signed quad triangles and unsigned point triangles.
    t_seg_tag r_d_tag;
    logic signed [TRI_W-1:0] r_d_t132, r_d_t234;
    logic [CROSS_W-1:0]      r_d_a12, r_d_a13, r_d_a34, r_d_a42;

    // Stage E: quad area and sum of the four point triangles.
    t_seg_tag           r_e_tag;
    logic [QUAD_W-1:0]  r_e_quad;
    logic [PARTS_W-1:0] r_e_parts;

    // Stage F: tolerance test.
    t_seg_res r_f_res;

    logic signed [AREA_W-1:0] w_diff;
    logic [AREA_W-1:0]        w_abs_diff;

    always_comb begin
        w_diff     = $signed(AREA_W'(r_e_quad)) - $signed(AREA_W'(r_e_parts));
        w_abs_diff = w_diff[AREA_W-1] ? AREA_W'(-w_diff) : AREA_W'(w_diff);
    end

    always_ff @(posedge i_clk) begin
        if (i_tag.valid) begin
            r_prev <= i_data;
        end

        r_a_1 <= rel_of(r_prev.outer_x, r_prev.outer_z, i_px, i_pz);
        r_a_2 <= rel_of(r_prev.inner_x, r_prev.inner_z, i_px, i_pz);
        r_a_3 <= rel_of(i_data.outer_x, i_data.outer_z, i_px, i_pz);
        r_a_4 <= rel_of(i_data.inner_x, i_data.inner_z, i_px, i_pz);

        r_b_12a <= PROD_W'(r_a_1.x) * PROD_W'(r_a_2.z);
        r_b_12b <= PROD_W'(r_a_1.z) * PROD_W'(r_a_2.x);
        r_b_13a <= PROD_W'(r_a_1.x) * PROD_W'(r_a_3.z);
        r_b_13b <= PROD_W'(r_a_1.z) * PROD_W'(r_a_3.x);
        r_b_34a <= PROD_W'(r_a_3.x) * PROD_W'(r_a_4.z);
        r_b_34b <= PROD_W'(r_a_3.z) * PROD_W'(r_a_4.x);
        r_b_42a <= PROD_W'(r_a_4.x) * PROD_W'(r_a_2.z);
        r_b_42b <= PROD_W'(r_a_4.z) * PROD_W'(r_a_2.x);
        r_b_23a <= PROD_W'(r_a_2.x) * PROD_W'(r_a_3.z);
        r_b_23b <= PROD_W'(r_a_2.z) * PROD_W'(r_a_3.x);

        r_c_12 <= CROSS_W'(r_b_12a) - CROSS_W'(r_b_12b);
        r_c_13 <= CROSS_W'(r_b_13a) - CROSS_W'(r_b_13b);
        r_c_34 <= CROSS_W'(r_b_34a) - CROSS_W'(r_b_34b);
        r_c_42 <= CROSS_W'(r_b_42a) - CROSS_W'(r_b_42b);
        r_c_23 <= CROSS_W'(r_b_23a) - CROSS_W'(r_b_23b);

        // Triangle (1,3,2) and (2,3,4) split the quad along its diagonal.
        r_d_t132 <= TRI_W'(r_c_13) - TRI_W'(r_c_23) - TRI_W'(r_c_12);
        r_d_t234 <= TRI_W'(r_c_23) + TRI_W'(r_c_34) + TRI_W'(r_c_42);
        r_d_a12  <= abs_cross(r_c_12);
        r_d_a13  <= abs_cross(r_c_13);
        r_d_a34  <= abs_cross(r_c_34);
        r_d_a42  <= abs_cross(r_c_42);

        r_e_quad  <= QUAD_W'(abs_tri(r_d_t132)) + QUAD_W'(abs_tri(r_d_t234));
        r_e_parts <= PARTS_W'(r_d_a12) + PARTS_W'(r_d_a13)
                   + PARTS_W'(r_d_a34) + PARTS_W'(r_d_a42);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_tag <= '0;
            r_b_tag <= '0;
            r_c_tag <= '0;
            r_d_tag <= '0;
            r_e_tag <= '0;
            r_f_res <= '0;
        end else begin
            r_a_tag <= '{valid:     i_tag.valid && i_tag.seg_valid,
                         seg_valid: i_tag.seg_valid,
                         last:      i_tag.last,
                         idx:       i_tag.idx};
            r_b_tag <= r_a_tag;
            r_c_tag <= r_b_tag;
            r_d_tag <= r_c_tag;
            r_e_tag <= r_d_tag;
            r_f_res <= '{valid: r_e_tag.valid,
                         last:  r_e_tag.last,
                         hit:   w_abs_diff < AREA_W'(i_tol),
                         idx:   r_e_tag.idx};
        end
    end

    assign o_res = r_f_res;

endmodule

// ===== hw/rtl/pqst_ctrl.sv =====
// ----------------------------------------------------------------------------
// pqst_ctrl
// Request handling, table walk sequencer and response register.
// ----------------------------------------------------------------------------
module pqst_ctrl #(
    parameter int DEPTH      = 256,
    parameter int COORD_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    pqst_req_if.sink             i_req,
    pqst_rsp_if.source           o_rsp,
    input  logic [8:0]           i_segment_count,
    input  pqst_pkg::t_seg_res   i_res,
    output pqst_pkg::t_wr_req    o_wr,
    output pqst_pkg::t_rd_req    o_rd,
    output logic signed [15:0]   o_px,
    output logic signed [15:0]   o_pz
);
    import pqst_pkg::*;

    localparam int SAT_W = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
    localparam logic signed [COORD_W-1:0] SAT_HI = COORD_W'((1 << (SAT_W - 1)) - 1);
    localparam logic signed [COORD_W-1:0] SAT_LO = -SAT_HI - COORD_W'(1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [COORD_W-1:0] v
    );
        logic signed [COORD_W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI;
        end else if (v < SAT_LO) begin
            r = SAT_LO;
        end else begin
            r = v;
        end
        return r;
    endfunction

    t_state r_state, n_state;

    logic [CNT_W-1:0] r_k;
    logic [CNT_W-1:0] r_count;
    logic signed [COORD_W-1:0] r_px, r_pz;
    logic             r_found;
    logic [IDX_W-1:0] r_hit_idx;
    logic             r_out_valid;
    logic             r_out_on;
    logic [IDX_W-1:0] r_out_idx;

    logic             w_ready;
    logic             w_fire;
    logic             w_query;
    logic             w_last_issue;
    logic             w_slot_free;
    logic             w_fin_load;
    logic [CNT_W-1:0] w_count;

    assign w_fire       = i_req.valid && w_ready;
    assign w_query      = w_fire && (i_req.cmd == CMD_QUERY);
    assign w_last_issue = (r_k == r_count);
    assign w_slot_free  = !r_out_valid || o_rsp.ready;
    assign w_fin_load   = (r_state == ST_FINISH) && w_slot_free;

    always_comb begin
        if (i_segment_count < SEG_COUNT_MIN) begin
            w_count = SEG_COUNT_MIN;
        end else if (i_segment_count > DEPTH_CNT) begin
            w_count = DEPTH_CNT;
        end else begin
            w_count = i_segment_count;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_query) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (w_last_issue) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_res.valid && i_res.last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    // State outputs. Reads run over entries 0..count-1 and then entry 0 again,
    // so that segment k-1 is ready when entry k (mod count) arrives.
    always_comb begin
        w_ready = 1'b0;
        o_rd    = '0;
        unique case (r_state)
            ST_IDLE: begin
                w_ready = 1'b1;
            end
            ST_WALK: begin
                o_rd.addr          = w_last_issue ? '0 : r_k[IDX_W-1:0];
                o_rd.tag.valid     = 1'b1;
                o_rd.tag.seg_valid = (r_k != '0);
                o_rd.tag.last      = w_last_issue;
                o_rd.tag.idx       = IDX_W'(r_k - CNT_W'(1));
            end
            ST_DRAIN, ST_FINISH: begin
                w_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_wr.en   = w_fire && (i_req.cmd == CMD_LOAD)
                    && ({1'b0, i_req.entry_index} < DEPTH_CNT);
        o_wr.addr = i_req.entry_index;
        o_wr.data.outer_x = sat_coord(i_req.outer_x);
        o_wr.data.outer_z = sat_coord(i_req.outer_z);
        o_wr.data.inner_x = sat_coord(i_req.inner_x);
        o_wr.data.inner_z = sat_coord(i_req.inner_z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= '0;
            r_count     <= SEG_COUNT_MIN;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_query) begin
                r_k     <= '0;
                r_count <= w_count;
                r_found <= 1'b0;
            end else if (r_state == ST_WALK) begin
                r_k <= r_k + CNT_W'(1);
            end
            // Segments come back in order, so the first hit is the one to keep.
            if (i_res.valid && i_res.hit && !r_found) begin
                r_found <= 1'b1;
            end
            if (w_fin_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_px <= sat_coord(i_req.point_x);
            r_pz <= sat_coord(i_req.point_z);
        end
        if (i_res.valid && i_res.hit && !r_found) begin
            r_hit_idx <= i_res.idx;
        end
        if (w_fin_load) begin
            r_out_on  <= r_found;
            r_out_idx <= r_found ? r_hit_idx : '0;
        end
    end

    assign i_req.ready       = w_ready;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.on_strip    = r_out_on;
    assign o_rsp.hit_segment = r_out_idx;
    assign o_px              = r_px;
    assign o_pz              = r_pz;

endmodule

// ===== hw/rtl/point_in_quad_strip_test_core.sv =====
// ----------------------------------------------------------------------------
// point_in_quad_strip_test_core
// Point-in-quad-strip test over a table of corner pairs in the x-z plane.
// ----------------------------------------------------------------------------
// The core holds a closed strip of quads as a table of outer and inner corner
// pairs (signed Q8.8) in one synchronous memory. A load request (cmd 0) writes
// one pair at entry_index and produces no response; indexes at or above the
// table depth are dropped. A query request (cmd 1) walks segments
// 0 .. count-1, where segment i is the quad built from pairs i and (i+1) mod
// count, and returns one response: on_strip is set when, for some segment,
// the doubled quad area and the sum of the four doubled triangle areas that
// the point forms with the quad's edges differ by less than area_tolerance;
// hit_segment gives the first such segment and is zero otherwise. All areas
// are exact integers in Q16.16 units. The response of a query is offered
// after count + 1 reads on the memory's single read port (entry 0 is read
// twice to close the strip, and each read lands in the memory's output
// register), the stages of the area pipeline, and the sequencer's DRAIN
// state, which waits for the last segment, and its FINISH state, which loads
// the response register once the previous response has been taken.
// The core accepts a new request whenever no query is in progress, even while
// a response waits on the output register.
// Entries must be loaded before a query reads them; unloaded entries hold
// unknown data. segment_count is clamped to the range 2 .. table depth.
// Configuration writes are accepted every cycle and must only be issued while
// no query is in progress.
// ----------------------------------------------------------------------------
module point_in_quad_strip_test_core #(
    parameter int MAX_SEGMENTS = 256,
    parameter int COORD_BITS   = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pqst_req_if.sink   i_req,
    pqst_rsp_if.source o_rsp,
    pqst_cfg_if.sink   i_cfg
);
    import pqst_pkg::*;

    // Entry indexes are 8 bits wide, so at most 256 entries are reachable.
    localparam int TABLE_DEPTH = (MAX_SEGMENTS < 256) ? MAX_SEGMENTS : 256;

    logic [CNT_W-1:0] r_segment_count;
    logic [TOL_W-1:0] r_area_tolerance;

    t_wr_req  w_wr;
    t_rd_req  w_rd;
    t_corner  w_rd_data;
    t_seg_tag w_rd_tag;
    t_seg_res w_res;
    logic signed [COORD_W-1:0] w_px, w_pz;

    // Configuration registers. The port never stalls.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_segment_count  <= SEG_COUNT_RESET;
            r_area_tolerance <= TOL_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_SEGMENT_COUNT: begin
                    r_segment_count <= i_cfg.data[CNT_W-1:0];
                end
                REG_AREA_TOLERANCE: begin
                    r_area_tolerance <= i_cfg.data[TOL_W-1:0];
                end
            endcase
        end
    end

    // Sequencer: takes requests, writes loads, issues the walk's reads and
    // holds the response.
    pqst_ctrl #(
        .DEPTH      (TABLE_DEPTH),
        .COORD_BITS (COORD_BITS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (i_req),
        .o_rsp           (o_rsp),
        .i_segment_count (r_segment_count),
        .i_res           (w_res),
        .o_wr            (w_wr),
        .o_rd            (w_rd),
        .o_px            (w_px),
        .o_pz            (w_pz)
    );

    // Corner pair table.
    pqst_table #(
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_wr),
        .i_rd      (w_rd),
        .o_rd_data (w_rd_data),
        .o_rd_tag  (w_rd_tag)
    );

    // Area comparison, one segment per cycle.
    pqst_area u_area (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (w_rd_data),
        .i_tag   (w_rd_tag),
        .i_px    (w_px),
        .i_pz    (w_pz),
        .i_tol   (r_area_tolerance),
        .o_res   (w_res)
    );

endmodule

// ===== hw/rtl/pqst_checker.sv =====
// ----------------------------------------------------------------------------
// pqst_checker
// Port-level checks for the point-in-quad-strip test core.
// ----------------------------------------------------------------------------
`include "point_in_quad_strip_test_core_assert.svh"

module pqst_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_valid,
    input logic       i_req_ready,
    input logic       i_req_cmd,
    input logic       i_rsp_valid,
    input logic       i_rsp_ready,
    input logic       i_rsp_on_strip,
    input logic [7:0] i_rsp_hit_segment
);
    import pqst_pkg::*;

    // A stalled response stays offered.
    `PQST_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid)

    // A stalled response keeps its payload.
    `PQST_ASSERT_NEXT(a_rsp_stable, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, $stable(i_rsp_on_strip) && $stable(i_rsp_hit_segment))

    // A miss reports segment zero.
    `PQST_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, i_rsp_valid && !i_rsp_on_strip, i_rsp_hit_segment == 8'd0)

    // A query occupies the core; no request is taken in the next cycle.
    `PQST_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, i_req_valid && i_req_ready && (i_req_cmd == CMD_QUERY), !i_req_ready)

    // A load leaves the core ready in the next cycle.
    `PQST_ASSERT_NEXT(a_load_ready, i_clk, i_rst_n, i_req_valid && i_req_ready && (i_req_cmd == CMD_LOAD), i_req_ready)

endmodule

bind point_in_quad_strip_test_core pqst_checker u_pqst_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_req_cmd         (i_req.cmd),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_on_strip    (o_rsp.on_strip),
    .i_rsp_hit_segment (o_rsp.hit_segment)
);
